FILE: rtl/two_level_adc_average_hysteresis_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-level ADC averaging core
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_ADC_AVERAGE_HYSTERESIS_CORE_MACROS_SVH
`define TWO_LEVEL_ADC_AVERAGE_HYSTERESIS_CORE_MACROS_SVH

// same-cycle implication
`define TLAH_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define TLAH_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/tlah_pkg.sv
// ----------------------------------------------------------------------------
// tlah_pkg
// Widths, register codes and shared types of the two-level ADC averaging core.
// ----------------------------------------------------------------------------
package tlah_pkg;

    localparam int CH_FIELD_W = 2;
    localparam int SAMPLE_W   = 10;
    localparam int DEC_W      = 7;
    localparam int CNT_W      = 6;
    localparam int SUM_W      = 16;
    localparam int CFG_IDX_W  = 8;

    localparam int NUM_DEC_REGS = 4;
    localparam int DEC_MAX      = 64;

    localparam int CHANNELS_DEFAULT   = 4;
    localparam int RING_DEPTH_DEFAULT = 8;
    localparam int Q_DEPTH            = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEC_CH0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEC_CH1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DEC_CH2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DEC_CH3 = CFG_IDX_W'(3);

    localparam logic [DEC_W-1:0] DEC_RESET [NUM_DEC_REGS] = '{7'd16, 7'd16, 7'd4, 7'd8};

    // classified sample handed from front to back
    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        logic                  ch_ok;
        logic                  complete;
        logic [SUM_W-1:0]      sum;
        logic [DEC_W-1:0]      dec;
    } queue_item_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DEC_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    // zero counts as one, anything above the maximum as the maximum
    function automatic logic [DEC_W-1:0] clamp_dec(input logic [DEC_W-1:0] d);
        logic [DEC_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DEC_W'(1);
        end
        else if (d > DEC_W'(DEC_MAX))
        begin
            r = DEC_W'(DEC_MAX);
        end
        return r;
    endfunction

endpackage

FILE: rtl/tlah_ifs.sv
// ----------------------------------------------------------------------------
// tlah channel interfaces
// Sample input, filtered result output and configuration write channels.
// ----------------------------------------------------------------------------
interface tlah_in_if;
    import tlah_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CH_FIELD_W-1:0] channel;
    logic [SAMPLE_W-1:0]   sample;
    modport source (output valid, channel, sample, input ready);
    modport sink   (input valid, channel, sample, output ready);
endinterface

interface tlah_out_if;
    import tlah_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CH_FIELD_W-1:0] out_channel;
    logic [SAMPLE_W-1:0]   filtered_value;
    logic                  new_mean;
    modport source (output valid, out_channel, filtered_value, new_mean, input ready);
    modport sink   (input valid, out_channel, filtered_value, new_mean, output ready);
endinterface

interface tlah_cfg_if;
    import tlah_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DEC_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tlah_front.sv
// ----------------------------------------------------------------------------
// tlah_front
// Accepts samples, keeps per-channel partial sums and counts, flags completed
// first-level means and pushes each classified beat into the queue.
// ----------------------------------------------------------------------------
module tlah_front #(
    parameter int CHANNELS = tlah_pkg::CHANNELS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tlah_in_if.sink              in_s,
    tlah_cfg_if.sink             cfg_s,
    output logic                 push_valid,
    input  logic                 push_ready,
    output tlah_pkg::queue_item_t push_item
);
    import tlah_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [DEC_W-1:0] dec_reg   [NUM_DEC_REGS];
    logic [SUM_W-1:0] psum_reg  [CHANNELS];
    logic [CNT_W-1:0] count_reg [CHANNELS];

    logic             accept;
    logic             ch_ok;
    logic [CH_W-1:0]  ch_idx;
    logic [DEC_W-1:0] dec_eff;
    logic [DEC_W-1:0] cnt_inc;
    logic [SUM_W-1:0] sum_inc;
    logic             complete;

    assign in_s.ready  = push_ready;
    assign cfg_s.ready = 1'b1;
    assign accept      = in_s.valid && push_ready;

    always_comb
    begin
        ch_ok    = 32'(in_s.channel) < CHANNELS;
        ch_idx   = CH_W'(in_s.channel);
        dec_eff  = clamp_dec(dec_reg[in_s.channel]);
        cnt_inc  = {1'b0, count_reg[ch_idx]} + DEC_W'(1);
        sum_inc  = psum_reg[ch_idx] + SUM_W'(in_s.sample);
        complete = ch_ok && (cnt_inc >= dec_eff);
    end

    assign push_valid         = in_s.valid;
    assign push_item.channel  = in_s.channel;
    assign push_item.ch_ok    = ch_ok;
    assign push_item.complete = complete;
    assign push_item.sum      = sum_inc;
    assign push_item.dec      = dec_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DEC_REGS; i++)
            begin
                dec_reg[i] <= DEC_RESET[i];
            end
        end
        else if (cfg_s.valid)
        begin
            case (cfg_s.index)
                REG_DEC_CH0: dec_reg[0] <= cfg_s.data;
                REG_DEC_CH1: dec_reg[1] <= cfg_s.data;
                REG_DEC_CH2: dec_reg[2] <= cfg_s.data;
                REG_DEC_CH3: dec_reg[3] <= cfg_s.data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                psum_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (accept && ch_ok)
        begin
            // restart the accumulation once a mean completes
            if (complete)
            begin
                psum_reg[ch_idx]  <= '0;
                count_reg[ch_idx] <= '0;
            end
            else
            begin
                psum_reg[ch_idx]  <= sum_inc;
                count_reg[ch_idx] <= cnt_inc[CNT_W-1:0];
            end
        end
    end

endmodule

FILE: rtl/tlah_queue.sv
// ----------------------------------------------------------------------------
// tlah_queue
// Short FIFO of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module tlah_queue #(
    parameter int DEPTH = tlah_pkg::Q_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  tlah_pkg::queue_item_t push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output tlah_pkg::queue_item_t pop_item
);
    import tlah_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    queue_item_t      store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic             push;
    logic             pop;

    assign push_ready = level_reg != LVL_W'(DEPTH);
    assign pop_valid  = level_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - LVL_W'(1);
            end
        end
    end

endmodule

FILE: rtl/tlah_div.sv
// ----------------------------------------------------------------------------
// tlah_div
// Restoring divider, one quotient bit per cycle, for the first-level mean.
// ----------------------------------------------------------------------------
module tlah_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tlah_pkg::div_req_t req,
    output tlah_pkg::div_rsp_t rsp
);
    import tlah_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  dq_reg;
    logic [DEC_W-1:0]  rem_reg;
    logic [DEC_W-1:0]  divisor_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEC_W:0]    trial;
    logic [DEC_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, dq_reg[SUM_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        ge    = trial >= {1'b0, divisor_reg};
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg      <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit into the remainder, quotient bit in at the bottom
            dq_reg  <= {dq_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEC_W-1:0] : trial[DEC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/tlah_back.sv
// ----------------------------------------------------------------------------
// tlah_back
// Drains the queue: divides completed sums, updates the ring of first-level
// means and its running total, applies the hysteresis and drives the result.
// ----------------------------------------------------------------------------
module tlah_back #(
    parameter int CHANNELS   = tlah_pkg::CHANNELS_DEFAULT,
    parameter int RING_DEPTH = tlah_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  tlah_pkg::queue_item_t pop_item,
    output tlah_pkg::div_req_t    div_req,
    input  tlah_pkg::div_rsp_t    div_rsp,
    tlah_out_if.source            out_s
);
    import tlah_pkg::*;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int MEM_DEPTH = CHANNELS * RING_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // ring average by the rounded-up reciprocal, exact for any 16-bit total
    localparam int RECIP_SH = SUM_W + $clog2(RING_DEPTH);
    localparam int PROD_W   = 2 * SUM_W + 1;
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(
        ((64'd1 << RECIP_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MEAN   = 2'd1;
    localparam logic [1:0] S_TOTAL  = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;

    logic [SAMPLE_W-1:0]   cur_reg    [CHANNELS];
    logic [SAMPLE_W-1:0]   prev_reg   [CHANNELS];
    logic [SUM_W-1:0]      total_reg  [CHANNELS];
    logic [POS_W-1:0]      pos_reg    [CHANNELS];
    logic                  filled_reg [CHANNELS];

    logic [SAMPLE_W-1:0]   ring_mem   [MEM_DEPTH];
    logic [SAMPLE_W-1:0]   rd_data_reg;

    logic [CH_FIELD_W-1:0] it_chan_reg;
    logic                  out_valid_reg;
    logic [CH_FIELD_W-1:0] out_ch_reg;
    logic [SAMPLE_W-1:0]   out_val_reg;
    logic                  out_new_reg;

    logic                  out_free;
    logic                  pop;
    logic [CH_W-1:0]       it_ch;
    logic [CH_W-1:0]       pop_ch;
    logic [ADDR_W-1:0]     ring_addr;
    logic                  ring_we;
    logic [SAMPLE_W-1:0]   mean;
    logic [SAMPLE_W-1:0]   old_mean;
    logic [SUM_W-1:0]      total_new;
    logic                  pos_last;
    logic                  quick_load;
    logic                  report_load;

    logic [PROD_W-1:0]     avg_prod;
    logic [SAMPLE_W-1:0]   cand;
    logic [SAMPLE_W:0]     cand_x;
    logic [SAMPLE_W:0]     cur_x;
    logic [SAMPLE_W:0]     prev_x;
    logic                  take;

    assign out_free  = !out_valid_reg || out_s.ready;
    assign pop_ready = (state_reg == S_IDLE) && (pop_item.complete || out_free);
    assign pop       = pop_valid && pop_ready;
    assign it_ch     = CH_W'(it_chan_reg);
    assign pop_ch    = CH_W'(pop_item.channel);
    assign ring_addr = ADDR_W'(int'(it_ch) * RING_DEPTH + int'(pos_reg[it_ch]));

    assign quick_load  = pop && !pop_item.complete;
    assign report_load = (state_reg == S_REPORT) && out_free;

    always_comb
    begin
        mean      = div_rsp.quotient[SAMPLE_W-1:0];
        old_mean  = filled_reg[it_ch] ? rd_data_reg : '0;
        total_new = total_reg[it_ch] - SUM_W'(old_mean) + SUM_W'(mean);
        pos_last  = pos_reg[it_ch] == POS_W'(RING_DEPTH - 1);
        ring_we   = (state_reg == S_MEAN) && div_rsp.done;
    end

    always_comb
    begin
        div_req.start    = pop && pop_item.complete;
        div_req.dividend = pop_item.sum;
        div_req.divisor  = pop_item.dec;
    end

    // a single step is kept only if it does not undo the previous step
    always_comb
    begin
        avg_prod = PROD_W'(total_reg[it_ch]) * PROD_W'(RECIP);
        cand     = avg_prod[RECIP_SH +: SAMPLE_W];
        cand_x   = {1'b0, cand};
        cur_x    = {1'b0, cur_reg[it_ch]};
        prev_x   = {1'b0, prev_reg[it_ch]};
        if (cand_x == cur_x + (SAMPLE_W + 1)'(1))
        begin
            take = !(cur_x + (SAMPLE_W + 1)'(1) == prev_x);
        end
        else if (cand_x + (SAMPLE_W + 1)'(1) == cur_x)
        begin
            take = !(prev_x + (SAMPLE_W + 1)'(1) == cur_x);
        end
        else
        begin
            take = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop && pop_item.complete)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_TOTAL;
                end
            end
            S_TOTAL:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_addr] <= mean;
        end
        rd_data_reg <= ring_mem[ring_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            it_chan_reg <= pop_item.channel;
        end
        if (quick_load)
        begin
            out_ch_reg  <= pop_item.channel;
            out_val_reg <= pop_item.ch_ok ? cur_reg[pop_ch] : '0;
            out_new_reg <= 1'b0;
        end
        else if (report_load)
        begin
            out_ch_reg  <= it_chan_reg;
            out_val_reg <= cur_reg[it_ch];
            out_new_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                cur_reg[i]    <= '0;
                prev_reg[i]   <= '0;
                total_reg[i]  <= '0;
                pos_reg[i]    <= '0;
                filled_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (quick_load || report_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_s.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ring_we)
            begin
                total_reg[it_ch] <= total_new;
                pos_reg[it_ch]   <= pos_last ? '0 : pos_reg[it_ch] + POS_W'(1);
                if (pos_last)
                begin
                    filled_reg[it_ch] <= 1'b1;
                end
            end
            if ((state_reg == S_TOTAL) && take)
            begin
                prev_reg[it_ch] <= cur_reg[it_ch];
                cur_reg[it_ch]  <= cand;
            end
        end
    end

    assign out_s.valid          = out_valid_reg;
    assign out_s.out_channel    = out_ch_reg;
    assign out_s.filtered_value = out_val_reg;
    assign out_s.new_mean       = out_new_reg;

endmodule

FILE: rtl/two_level_adc_average_hysteresis_core.sv
// ----------------------------------------------------------------------------
// two_level_adc_average_hysteresis_core
// Per-channel decimating average into a ring of means, ring average and
// +/-1 hysteresis, with a queue between the classifying front and the back.
// ----------------------------------------------------------------------------
//  beat        | dir | handshake   | payload
//  sample_in   | in  | valid/ready | channel, sample
//  result_out  | out | valid/ready | out_channel, filtered_value, new_mean
//  cfg         | in  | valid/ready | index, data (decimation per channel)
//
//  A sample that does not complete a mean is queued when accepted and popped
//  into the result register once the back is idle and the result is free,
//  so these beats stream at one per cycle while results are taken.
//  A sample that completes a mean holds the back through the 16-step division
//  of the sum by the decimation, the ring and total write when it is done, the
//  ring average and hysteresis, and then the load of the result.
//  Reset leaves the ring memory; the ring is tracked by a per-channel fill
//  flag. The queue lets the front take samples while a result waits.
// ----------------------------------------------------------------------------
`include "two_level_adc_average_hysteresis_core_macros.svh"

module two_level_adc_average_hysteresis_core #(
    parameter int CHANNELS    = tlah_pkg::CHANNELS_DEFAULT,
    parameter int RING_DEPTH  = tlah_pkg::RING_DEPTH_DEFAULT,
    parameter int QUEUE_DEPTH = tlah_pkg::Q_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    tlah_in_if.sink    sample_in,
    tlah_out_if.source result_out,
    tlah_cfg_if.sink   cfg
);
    import tlah_pkg::*;

    logic        q_push_valid;
    logic        q_push_ready;
    queue_item_t q_push_item;
    logic        q_pop_valid;
    logic        q_pop_ready;
    queue_item_t q_pop_item;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    tlah_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_s       (sample_in),
        .cfg_s      (cfg),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item)
    );

    tlah_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    tlah_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tlah_back #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_item  (q_pop_item),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_s     (result_out)
    );

    // the divider is never restarted mid-division
    `TLAH_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)
    // done is a single-cycle pulse
    `TLAH_ASSERT_NXT(a_div_done_pulse, clk, rst_n, div_rsp.done, !div_rsp.done)
    // a completed mean popped from the queue starts its division at once
    `TLAH_ASSERT_IMP(a_pop_starts_div, clk, rst_n,
        q_pop_valid && q_pop_ready && q_pop_item.complete, div_req.start)

endmodule
